@@ src/assert_macros.svh @@
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CHK_IMPLY(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
`define CHK_NEXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define CHK_IMPLY(lbl, ck, rstn, ante, cons)
`define CHK_NEXT(lbl, ck, rstn, ante, cons)
`endif
`endif

@@ src/ddo_pkg.sv @@
package ddo_pkg;

	localparam int HEADING_BITS = 16;
	localparam int TW_W = 31;
	localparam int CW = 34;
	localparam int CORDIC_ITERS = 30;
	localparam int ITER_W = 5;
	localparam int STEP_W = 7;
	localparam logic [STEP_W-1:0] DIV1_STEPS = 7'd64;
	localparam logic [STEP_W-1:0] DIV2_STEPS = 7'd32;
	localparam logic [31:0] PHASE_K = 32'd2734261103;
	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [CW-1:0] ONE_Q30 = 34'sd1073741824;
	localparam logic [TW_W-1:0] TW_RESET = 31'd65536;

	typedef struct packed {
		logic action;
		logic signed [31:0] wheel0_angle;
		logic signed [31:0] wheel1_angle;
		logic signed [31:0] new_x;
		logic signed [31:0] new_y;
		logic [15:0] new_heading;
	} item_t;

	typedef struct packed {
		logic signed [31:0] pose_x;
		logic signed [31:0] pose_y;
		logic [15:0] pose_heading;
		logic signed [31:0] wheel0_now;
		logic signed [31:0] wheel1_now;
	} res_t;

	typedef struct packed {
		logic start;
		logic [64:0] rem_init;
		logic [63:0] num;
		logic [64:0] den;
		logic [STEP_W-1:0] steps;
	} div_cmd_t;

	typedef enum logic [4:0] {
		S_IDLE, S_PREP, S_CHK, S_DIV1, S_PH1, S_PH2, S_PH3, S_SSTART, S_SCORD,
		S_F1, S_F2, S_F3, S_F4, S_DIV2S, S_DIV2, S_HSTART, S_HCORD,
		S_R1, S_R2, S_R3, S_R4, S_R5, S_DONE
	} state_t;

	function automatic logic [29:0] atan_entry(input logic [ITER_W-1:0] i);
		logic [29:0] a;
		case (i)
			5'd0: a = 30'd536870912;
			5'd1: a = 30'd316933406;
			5'd2: a = 30'd167458907;
			5'd3: a = 30'd85004756;
			5'd4: a = 30'd42667331;
			5'd5: a = 30'd21354465;
			5'd6: a = 30'd10679838;
			5'd7: a = 30'd5340245;
			5'd8: a = 30'd2670163;
			5'd9: a = 30'd1335087;
			5'd10: a = 30'd667544;
			5'd11: a = 30'd333772;
			5'd12: a = 30'd166886;
			5'd13: a = 30'd83443;
			5'd14: a = 30'd41722;
			5'd15: a = 30'd20861;
			5'd16: a = 30'd10430;
			5'd17: a = 30'd5215;
			5'd18: a = 30'd2608;
			5'd19: a = 30'd1304;
			5'd20: a = 30'd652;
			5'd21: a = 30'd326;
			5'd22: a = 30'd163;
			5'd23: a = 30'd81;
			5'd24: a = 30'd41;
			5'd25: a = 30'd20;
			5'd26: a = 30'd10;
			5'd27: a = 30'd5;
			5'd28: a = 30'd3;
			5'd29: a = 30'd1;
			default: a = 30'd0;
		endcase
		return a;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
		logic signed [31:0] r;
		if (v > 48'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -48'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

@@ src/ddo_cordic.sv @@
module ddo_cordic (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [31:0] phase,
	output logic done,
	output logic signed [ddo_pkg::CW-1:0] cos_val,
	output logic signed [ddo_pkg::CW-1:0] sin_val
);
	import ddo_pkg::*;

	logic signed [CW-1:0] x_q, y_q, z_q;
	logic [ITER_W-1:0] it_q;
	logic busy_q, done_q, flip_q;
	logic flip_c;
	logic [31:0] p_c;
	logic signed [CW-1:0] xs_c, ys_c, at_c;

	localparam logic [ITER_W-1:0] LAST_IT = ITER_W'(CORDIC_ITERS - 1);

	// fold the phase into the half circle around zero
	assign flip_c = ((phase + 32'h40000000) & 32'h80000000) != 32'd0;
	assign p_c = flip_c ? (phase ^ 32'h80000000) : phase;

	assign xs_c = x_q >>> it_q;
	assign ys_c = y_q >>> it_q;
	assign at_c = $signed({4'b0, atan_entry(it_q)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			it_q <= '0;
		end else begin
			done_q <= busy_q && (it_q == LAST_IT);
			if (start) begin
				busy_q <= 1'b1;
				it_q <= '0;
			end else if (busy_q) begin
				if (it_q == LAST_IT) begin
					busy_q <= 1'b0;
				end
				it_q <= it_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= CORDIC_GAIN;
			y_q <= '0;
			z_q <= CW'($signed(p_c));
			flip_q <= flip_c;
		end else if (busy_q) begin
			if (!z_q[CW-1]) begin
				x_q <= x_q - ys_c;
				y_q <= y_q + xs_c;
				z_q <= z_q - at_c;
			end else begin
				x_q <= x_q + ys_c;
				y_q <= y_q - xs_c;
				z_q <= z_q + at_c;
			end
		end
	end

	assign done = done_q;
	assign cos_val = flip_q ? -x_q : x_q;
	assign sin_val = flip_q ? -y_q : y_q;

endmodule

@@ src/ddo_div.sv @@
module ddo_div (
	input logic clk,
	input logic arst_n,
	input ddo_pkg::div_cmd_t cmd,
	output logic done,
	output logic [63:0] quot
);
	import ddo_pkg::*;

	logic [64:0] rem_q, den_q;
	logic [63:0] num_q, q_q;
	logic [STEP_W-1:0] cnt_q;
	logic done_q;
	logic [65:0] trial_c, diff_c;
	logic ge_c;

	// restoring division, one quotient bit per cycle
	assign trial_c = {rem_q, num_q[63]};
	assign diff_c = trial_c - {1'b0, den_q};
	assign ge_c = trial_c >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == STEP_W'(1)) && !cmd.start;
			if (cmd.start) begin
				cnt_q <= cmd.steps;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q <= cmd.rem_init;
			num_q <= cmd.num;
			den_q <= cmd.den;
			q_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= ge_c ? diff_c[64:0] : trial_c[64:0];
			num_q <= {num_q[62:0], 1'b0};
			q_q <= {q_q[62:0], ge_c};
		end
	end

	assign done = done_q;
	assign quot = q_q;

endmodule

@@ src/differential_drive_odometry_unit.sv @@
// planar odometry: one item at a time, item_ready only while idle
// set pose: straight to the done state, which raises res_valid unless stalled
// straight move: heading sine and cosine, then rotation
// turning move: bit-serial divider (64 steps, then up to 2x32 steps)
// and two 30-step cordic runs, all on one shared 35x35 multiplier
// arst_n clears the pose and wheel angles, track width resets to 1.0
`include "assert_macros.svh"
module differential_drive_odometry_unit (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_ready,
	input ddo_pkg::item_t item,
	output logic res_valid,
	input logic res_ready,
	output ddo_pkg::res_t res,
	input logic cfg_we,
	input logic [ddo_pkg::TW_W-1:0] cfg_wdata
);
	import ddo_pkg::*;

	state_t state_q, state_d;

	logic [TW_W-1:0] tw_q, w_c;
	logic signed [31:0] wheel0_q, wheel1_q, x_q, y_q;
	logic [HEADING_BITS-1:0] hd_q;
	logic signed [33:0] dq0_q, dq1_q;
	logic signed [34:0] sum_q, diff_q, nsum_c, ndiff_c;
	logic [32:0] msum_c, mdiff_c;
	logic [63:0] phiu_q;
	logic [31:0] ph_hi_q, step_ph_q;
	logic signed [CW-1:0] sc_c_q, sc_s_q, hc_q, hs_q, f_c, nf_c;
	logic [32:0] magf_c;
	logic sel_q, neg_q;
	logic [30:0] ahi_q;
	logic [95:0] p_q;
	logic signed [31:0] dx_q, dy_q, step_res_c;
	logic signed [69:0] mul_q, acc_q, acc_sh_c, accy_c, accy_sh_c;
	logic signed [34:0] op_a, op_b;
	logic [31:0] cap_c, m_c;
	logic sat_c;
	logic res_valid_q;
	res_t res_q;

	div_cmd_t div_cmd;
	logic div_done;
	logic [63:0] div_q;
	logic cor_start, cor_done;
	logic [31:0] cor_phase;
	logic signed [CW-1:0] cor_cos, cor_sin;

	assign w_c = (tw_q == '0) ? TW_W'(1) : tw_q;
	assign nsum_c = -sum_q;
	assign ndiff_c = -diff_q;
	assign msum_c = sum_q[34] ? nsum_c[32:0] : sum_q[32:0];
	assign mdiff_c = diff_q[34] ? ndiff_c[32:0] : diff_q[32:0];
	assign f_c = sel_q ? (ONE_Q30 - sc_c_q) : sc_s_q;
	assign nf_c = -f_c;
	assign magf_c = f_c[CW-1] ? nf_c[32:0] : f_c[32:0];
	assign sat_c = p_q[95:32] >= {mdiff_c, 31'b0};
	assign cap_c = neg_q ? 32'h80000000 : 32'h7fffffff;
	assign m_c = (state_q == S_DIV2S) ? cap_c :
		((div_q[31:0] > cap_c) ? cap_c : div_q[31:0]);
	assign step_res_c = neg_q ? -$signed(m_c) : $signed(m_c);
	assign acc_sh_c = acc_q >>> 30;
	assign accy_c = acc_q + mul_q;
	assign accy_sh_c = accy_c >>> 30;

	ddo_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(div_cmd),
		.done(div_done),
		.quot(div_q)
	);

	ddo_cordic u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.start(cor_start),
		.phase(cor_phase),
		.done(cor_done),
		.cos_val(cor_cos),
		.sin_val(cor_sin)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (item_valid) begin
				state_d = item.action ? S_DONE : S_PREP;
			end
			S_PREP: state_d = S_CHK;
			S_CHK: state_d = (diff_q == '0) ? S_HSTART : S_DIV1;
			S_DIV1: if (div_done) begin
				state_d = (div_q == '0) ? S_HSTART : S_PH1;
			end
			S_PH1: state_d = S_PH2;
			S_PH2: state_d = S_PH3;
			S_PH3: state_d = S_SSTART;
			S_SSTART: state_d = S_SCORD;
			S_SCORD: if (cor_done) begin
				state_d = S_F1;
			end
			S_F1: state_d = S_F2;
			S_F2: state_d = S_F3;
			S_F3: state_d = S_F4;
			S_F4: state_d = S_DIV2S;
			S_DIV2S: begin
				if (!sat_c) begin
					state_d = S_DIV2;
				end else begin
					state_d = sel_q ? S_HSTART : S_F1;
				end
			end
			S_DIV2: if (div_done) begin
				state_d = sel_q ? S_HSTART : S_F1;
			end
			S_HSTART: state_d = S_HCORD;
			S_HCORD: if (cor_done) begin
				state_d = S_R1;
			end
			S_R1: state_d = S_R2;
			S_R2: state_d = S_R3;
			S_R3: state_d = S_R4;
			S_R4: state_d = S_R5;
			S_R5: state_d = S_DONE;
			S_DONE: if (!res_valid_q || res_ready) begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control outputs and shared multiplier operands
	always_comb begin
		item_ready = 1'b0;
		div_cmd = '0;
		cor_start = 1'b0;
		cor_phase = step_ph_q;
		op_a = '0;
		op_b = '0;
		case (state_q)
			S_IDLE: item_ready = 1'b1;
			S_CHK: begin
				div_cmd.start = (diff_q != '0);
				div_cmd.rem_init = '0;
				div_cmd.num = {1'b0, mdiff_c, 30'b0};
				div_cmd.den = {34'b0, w_c};
				div_cmd.steps = DIV1_STEPS;
			end
			S_PH1: begin
				op_a = {3'b0, phiu_q[31:0]};
				op_b = {3'b0, PHASE_K};
			end
			S_PH2: begin
				op_a = {3'b0, phiu_q[63:32]};
				op_b = {3'b0, PHASE_K};
			end
			S_SSTART: cor_start = 1'b1;
			S_F1: begin
				op_a = {2'b0, magf_c};
				op_b = {4'b0, w_c};
			end
			S_F2: begin
				op_a = {3'b0, mul_q[31:0]};
				op_b = {2'b0, msum_c};
			end
			S_F3: begin
				op_a = {4'b0, ahi_q};
				op_b = {2'b0, msum_c};
			end
			S_DIV2S: begin
				div_cmd.start = !sat_c;
				div_cmd.rem_init = {1'b0, p_q[95:32]};
				div_cmd.num = {p_q[31:0], 32'b0};
				div_cmd.den = {1'b0, mdiff_c, 31'b0};
				div_cmd.steps = DIV2_STEPS;
			end
			S_HSTART: begin
				cor_start = 1'b1;
				cor_phase = 32'(hd_q) << (32 - HEADING_BITS);
			end
			S_R1: begin
				op_a = 35'(dx_q);
				op_b = 35'(hc_q);
			end
			S_R2: begin
				op_a = 35'(dy_q);
				op_b = 35'(hs_q);
			end
			S_R3: begin
				op_a = 35'(dx_q);
				op_b = 35'(hs_q);
			end
			S_R4: begin
				op_a = 35'(dy_q);
				op_b = 35'(hc_q);
			end
			default: begin
				op_a = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		mul_q <= op_a * op_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tw_q <= TW_RESET;
			wheel0_q <= '0;
			wheel1_q <= '0;
			x_q <= '0;
			y_q <= '0;
			hd_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				tw_q <= cfg_wdata;
			end
			if (state_q == S_IDLE && item_valid) begin
				if (item.action) begin
					x_q <= item.new_x;
					y_q <= item.new_y;
					hd_q <= HEADING_BITS'(item.new_heading);
				end else begin
					wheel0_q <= item.wheel0_angle;
					wheel1_q <= item.wheel1_angle;
				end
			end
			if (state_q == S_R4) begin
				x_q <= sat32(48'(x_q) + $signed(acc_sh_c[47:0]));
			end
			if (state_q == S_R5) begin
				y_q <= sat32(48'(y_q) + $signed(accy_sh_c[47:0]));
				hd_q <= hd_q + step_ph_q[31 -: HEADING_BITS];
			end
			if (state_q == S_DONE && (!res_valid_q || res_ready)) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				dq0_q <= 34'(item.wheel0_angle) - 34'(wheel0_q);
				dq1_q <= 34'(item.wheel1_angle) - 34'(wheel1_q);
			end
			S_PREP: begin
				sum_q <= 35'(dq0_q) + 35'(dq1_q);
				diff_q <= 35'(dq0_q) - 35'(dq1_q);
				step_ph_q <= '0;
				sel_q <= 1'b0;
			end
			S_CHK: begin
				dx_q <= sat32(48'(dq0_q));
				dy_q <= '0;
			end
			S_DIV1: if (div_done) begin
				// turn below resolution falls back to a straight step
				dx_q <= sat32(48'(sum_q >>> 1));
				phiu_q <= diff_q[34] ? -div_q : div_q;
			end
			S_PH2: ph_hi_q <= mul_q[63:32];
			S_PH3: step_ph_q <= ph_hi_q + mul_q[31:0];
			S_SCORD: if (cor_done) begin
				sc_c_q <= cor_cos;
				sc_s_q <= cor_sin;
			end
			S_F1: neg_q <= f_c[CW-1] ^ sum_q[34] ^ diff_q[34];
			S_F2: ahi_q <= mul_q[62:32];
			S_F3: p_q <= {30'b0, mul_q[65:0]};
			S_F4: p_q <= p_q + {mul_q[63:0], 32'b0};
			S_DIV2S: if (sat_c) begin
				if (sel_q) begin
					dy_q <= step_res_c;
				end else begin
					dx_q <= step_res_c;
				end
				sel_q <= 1'b1;
			end
			S_DIV2: if (div_done) begin
				if (sel_q) begin
					dy_q <= step_res_c;
				end else begin
					dx_q <= step_res_c;
				end
				sel_q <= 1'b1;
			end
			S_HCORD: if (cor_done) begin
				hc_q <= cor_cos;
				hs_q <= cor_sin;
			end
			S_R2: acc_q <= mul_q;
			S_R3: acc_q <= acc_q - mul_q;
			S_R4: acc_q <= mul_q;
			S_DONE: if (!res_valid_q || res_ready) begin
				res_q.pose_x <= x_q;
				res_q.pose_y <= y_q;
				res_q.pose_heading <= 16'(hd_q);
				res_q.wheel0_now <= wheel0_q;
				res_q.wheel1_now <= wheel1_q;
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

	`CHK_NEXT(a_set_pose_quick, clk, arst_n, item_valid && item_ready && item.action, state_q == S_DONE)
	`CHK_IMPLY(a_cordic_waited, clk, arst_n, cor_done, state_q == S_SCORD || state_q == S_HCORD)
	`CHK_IMPLY(a_div_waited, clk, arst_n, div_done, state_q == S_DIV1 || state_q == S_DIV2)

endmodule

@@ bench/differential_drive_odometry_unit_test.sv @@
`timescale 1ns / 1ps
module differential_drive_odometry_unit_test;
	import ddo_pkg::*;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_ready;
	item_t item;
	logic res_valid;
	logic res_ready;
	res_t res;
	logic cfg_we;
	logic [TW_W-1:0] cfg_wdata;

	differential_drive_odometry_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	localparam longint ARC_TAB [30] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
		10, 5, 3, 1
	};
	localparam longint GAIN_Q30 = 652032874;
	localparam longint UNIT_Q30 = 1073741824;
	localparam longint unsigned TURN_K = 64'd2734261103;

	// tracked odometry state and width
	logic [TW_W-1:0] width_q;
	logic signed [31:0] wheel0_q, wheel1_q, x_q, y_q;
	logic [15:0] heading_q;

	res_t pose_queue[$];
	int taken_items;
	int bad_count;
	bit sender_calm;
	int stall_left;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic signed [31:0] clip32(input longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic longint unsigned magnitude(input longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic void rotate_phase(input logic [31:0] phase, output longint c,
			output longint s);
		bit flip;
		logic [31:0] p;
		longint z, x, y, nx;
		flip = ((phase + 32'h40000000) & 32'h80000000) != 0;
		p = flip ? (phase ^ 32'h80000000) : phase;
		z = longint'($signed(p));
		x = GAIN_Q30;
		y = 0;
		for (int i = 0; i < 30; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= ARC_TAB[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += ARC_TAB[i];
			end
			x = nx;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	// f * w * sum / diff >> 31, sign from the three operands, saturated
	function automatic longint arc_step(input longint f, input longint sum,
			input longint diff, input longint unsigned w);
		bit neg;
		logic [127:0] prod, q;
		longint unsigned cap;
		longint unsigned m;
		neg = (f < 0) ^ (sum < 0) ^ (diff < 0);
		cap = neg ? 64'h80000000 : 64'h7fffffff;
		prod = 128'(magnitude(f)) * 128'(w) * 128'(magnitude(sum));
		q = (prod / 128'(magnitude(diff))) >> 31;
		m = (q > 128'(cap)) ? cap : q[63:0];
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic res_t advance_pose(input item_t it);
		res_t r;
		longint dq0, dq1, sum, diff, dx, dy, hc, hs, c, s;
		longint unsigned w, phim, phiu;
		logic [31:0] turn;
		if (it.action) begin
			x_q = it.new_x;
			y_q = it.new_y;
			heading_q = it.new_heading;
		end else begin
			dq0 = longint'(it.wheel0_angle) - longint'(wheel0_q);
			dq1 = longint'(it.wheel1_angle) - longint'(wheel1_q);
			sum = dq0 + dq1;
			diff = dq0 - dq1;
			w = (width_q == 0) ? 1 : width_q;
			turn = 0;
			wheel0_q = it.wheel0_angle;
			wheel1_q = it.wheel1_angle;
			if (diff == 0) begin
				dx = clip32(dq0);
				dy = 0;
			end else begin
				phim = (magnitude(diff) << 30) / w;
				if (phim == 0) begin
					dx = clip32(sum >>> 1);
					dy = 0;
				end else begin
					phiu = diff < 0 ? -phim : phim;
					turn = 32'((phiu * TURN_K) >> 32);
					rotate_phase(turn, c, s);
					dx = arc_step(s, sum, diff, w);
					dy = arc_step(UNIT_Q30 - c, sum, diff, w);
				end
			end
			rotate_phase({heading_q, 16'h0}, hc, hs);
			x_q = clip32(longint'(x_q) + ((dx * hc - dy * hs) >>> 30));
			y_q = clip32(longint'(y_q) + ((dx * hs + dy * hc) >>> 30));
			heading_q = heading_q + turn[31:16];
		end
		r.pose_x = x_q;
		r.pose_y = y_q;
		r.pose_heading = heading_q;
		r.wheel0_now = wheel0_q;
		r.wheel1_now = wheel1_q;
		return r;
	endfunction

	// typed expectations from the directed table override the prediction
	bit typed_valid;
	res_t typed_res;

	always @(posedge clk) begin
		res_t p, e;
		if (item_valid && item_ready) begin
			p = advance_pose(item);
			pose_queue = {pose_queue, (typed_valid ? typed_res : p)};
			taken_items <= taken_items + 1;
		end
		if (res_valid && res_ready) begin
			if (pose_queue.size() == 0) begin
				bad_count++;
				if (bad_count <= 10) $display("unexpected item: %p", res);
			end else begin
				e = pose_queue.pop_front();
				if (res.pose_x !== e.pose_x || res.pose_y !== e.pose_y
						|| res.pose_heading !== e.pose_heading
						|| res.wheel0_now !== e.wheel0_now
						|| res.wheel1_now !== e.wheel1_now) begin
					bad_count++;
					if (bad_count <= 10)
						$display("mismatch: expected %p, got %p", e, res);
				end
			end
		end
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			res_ready <= 1'b0;
		end else if (!sender_calm && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 17) - 1;
			res_ready <= 1'b0;
		end else begin
			res_ready <= 1'b1;
		end
	end

	// starts and ends at a falling edge, valid left high
	task automatic send_item(input item_t it, input bit has_typed, input res_t tr);
		int prior;
		int gap;
		gap = 0;
		if (!sender_calm && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 17);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		typed_valid <= has_typed;
		typed_res <= tr;
		prior = taken_items;
		do @(negedge clk); while (taken_items == prior);
	endtask

	task automatic drain_and_set_width(input logic [TW_W-1:0] w);
		item_valid <= 1'b0;
		typed_valid <= 1'b0;
		while (pose_queue.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= w;
		width_q = w;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic item_t make_move(input logic signed [31:0] w0,
			input logic signed [31:0] w1);
		item_t it;
		it = '0;
		it.wheel0_angle = w0;
		it.wheel1_angle = w1;
		it.new_x = $urandom;
		it.new_y = $urandom;
		it.new_heading = 16'($urandom);
		return it;
	endfunction

	function automatic item_t make_pose(input logic signed [31:0] px,
			input logic signed [31:0] py, input logic [15:0] h);
		item_t it;
		it.action = 1'b1;
		it.wheel0_angle = $urandom;
		it.wheel1_angle = $urandom;
		it.new_x = px;
		it.new_y = py;
		it.new_heading = h;
		return it;
	endfunction

	function automatic res_t pose_of(input logic signed [31:0] px,
			input logic signed [31:0] py, input logic [15:0] h,
			input logic signed [31:0] w0, input logic signed [31:0] w1);
		res_t r;
		r.pose_x = px;
		r.pose_y = py;
		r.pose_heading = h;
		r.wheel0_now = w0;
		r.wheel1_now = w1;
		return r;
	endfunction

	function automatic item_t random_item();
		logic signed [31:0] d0, d1;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 8) return make_pose($urandom, $urandom, 16'($urandom));
		if (pick < 14) return make_move($urandom, $urandom);
		d0 = $signed($urandom) >>> $urandom_range(8, 30);
		d1 = (pick < 30) ? d0 : ($signed($urandom) >>> $urandom_range(8, 30));
		return make_move(wheel0_q + d0, wheel1_q + d1);
	endfunction

	typedef struct {
		item_t it;
		bit has_typed;
		res_t tr;
	} row_t;

	localparam logic signed [31:0] SMAX = 32'sh7fffffff;
	localparam logic signed [31:0] SMIN = 32'sh80000000;

	initial begin
		row_t rows[$];
		logic [TW_W-1:0] widths[5];
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		res_ready = 1'b0;
		typed_valid = 1'b0;
		typed_res = '0;
		sender_calm = 1'b0;
		stall_left = 0;
		taken_items = 0;
		bad_count = 0;
		width_q = TW_RESET;
		wheel0_q = 0;
		wheel1_q = 0;
		x_q = 0;
		y_q = 0;
		heading_q = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		rows = {rows, row_t'{make_move(0, 0), 1, pose_of(0, 0, 0, 0, 0)}};
		rows = {rows, row_t'{make_pose(SMAX, SMIN, 16'hffff), 1,
			pose_of(SMAX, SMIN, 16'hffff, 0, 0)}};
		rows = {rows, row_t'{make_pose(0, 0, 0), 1, pose_of(0, 0, 0, 0, 0)}};
		rows = {rows, row_t'{make_move(32'sh10000, 32'sh10000), 0, '0}};
		rows = {rows, row_t'{make_move(32'sh20000, 32'sh18000), 0, '0}};
		rows = {rows, row_t'{make_move(32'sh18000, 32'sh30000), 0, '0}};
		rows = {rows, row_t'{make_move(SMAX, SMIN), 0, '0}};
		rows = {rows, row_t'{make_move(SMIN, SMAX), 0, '0}};
		rows = {rows, row_t'{make_move(SMAX, SMAX), 0, '0}};
		rows = {rows, row_t'{make_pose(SMAX, SMAX, 16'h0000), 0, '0}};
		rows = {rows, row_t'{make_move(SMIN, SMIN), 0, '0}};
		rows = {rows, row_t'{make_pose(SMIN, SMIN, 16'h8000), 0, '0}};
		rows = {rows, row_t'{make_move(SMAX, SMAX), 0, '0}};
		rows = {rows, row_t'{make_pose(0, 0, 16'h4000), 0, '0}};
		rows = {rows, row_t'{make_move(-32'sh10000, 32'sh10000), 0, '0}};
		rows = {rows, row_t'{make_move(32'sh1, 32'sh0), 0, '0}};
		foreach (rows[i]) send_item(rows[i].it, rows[i].has_typed, rows[i].tr);

		// widest track: a one-lsb difference turns below resolution
		drain_and_set_width(31'h7fffffff);
		send_item(make_move(wheel0_q + 1, wheel1_q), 0, '0);
		send_item(make_move(wheel0_q, wheel1_q + 3), 0, '0);
		send_item(make_move(wheel0_q + 32'sh40000000, wheel1_q - 32'sh40000000), 0, '0);
		drain_and_set_width(31'd1);
		send_item(make_move(wheel0_q + 1, wheel1_q), 0, '0);
		send_item(make_move(SMIN, SMAX), 0, '0);

		widths = '{31'd1, 31'h7fffffff, 31'($urandom), TW_RESET, 31'd30000};
		for (int ph = 0; ph < 5; ph++) begin
			drain_and_set_width(widths[ph] == 0 ? 31'd1 : widths[ph]);
			if (ph == 4) sender_calm = 1'b1;
			for (int n = 0; n < 300; n++) send_item(random_item(), 0, '0);
		end
		item_valid <= 1'b0;
		while (pose_queue.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
		if (bad_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#40ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule
